[rtl/lvm_pkg.sv]
package lvm_pkg;

  // Number format: signed two's complement, DW bits, FRAC_BITS fraction bits.
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;

  // A unit component has a magnitude of at most 1.0.
  localparam int QW  = FRAC_BITS + 1;
  localparam int UW  = FRAC_BITS + 2;

  // Products and sums around the cross and dot products.
  localparam int XPW = UW + DW;
  localparam int CW  = XPW + 1;
  localparam int DTW = UW + DW + 2;
  localparam int UPW = 2 * UW;
  localparam int UCW = 2 * UW + 1;
  localparam int EPW = 2 * DW;
  localparam int RW  = 2 * DW + 2;

  // Normaliser: magnitudes are scaled until the largest has its top bit at MT.
  localparam int PW       = $clog2(CW);
  localparam int NMW      = 30;
  localparam int MT       = NMW - 1;
  localparam int SQW      = 2 * NMW + 2;
  localparam int SQ_STEPS = NMW + 1;
  localparam int LW       = NMW + 1;
  localparam int DVW      = LW + QW;
  localparam int NORM_LAT = 7 + SQ_STEPS + QW;

  typedef logic [1:0] col_t;
  localparam col_t LAST_COL = 2'd3;

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [PW-1:0] lead_one(input logic [CW-1:0] v);
    logic [PW-1:0] p;
    p = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) begin
        p = PW'(i);
      end
    end
    return p;
  endfunction

  // Drops FRAC_BITS fraction bits, rounding half away from zero.
  function automatic logic signed [RW-1:0] round_frac(input logic signed [RW-1:0] v);
    logic [RW-1:0] m;
    logic [RW-1:0] r;
    m = v[RW-1] ? RW'(-v) : RW'(v);
    r = (m + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[RW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [RW-1:0] v);
    logic signed [DW-1:0] r;
    if ((&v[RW-1:DW-1]) || !(|v[RW-1:DW-1])) begin
      r = v[DW-1:0];
    end else if (v[RW-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/look_at_view_matrix_unit.sv]
// Look-at view matrix unit. A request carries an eye point, a target point and an
// up vector in signed Q16.16; the unit answers with the 4x4 right-handed view matrix
// in column-major order as four results, column 0 first, with last_column set on
// the fourth. Columns 0 to 2 hold (s, u, -f, 0) for the x, y and z components, and
// column 3 holds the translation (-s.eye, -u.eye, f.eye, 1.0), saturated to the
// 32-bit range. The degenerate flag, the same on all four columns, reports that
// target equalled eye or that the forward vector was parallel to the up vector
// (or the up vector was zero); the affected unit vector is then zero. The datapath
// is a single pipeline of 120 register stages, the request register included.
// The output register sends one column per cycle while out_ready stays high,
// and it is this four-column serialiser that sets the sustained rate: requests
// are taken only while it is empty or is sending its last column.
// When the result side stalls, the whole pipeline holds, so nothing is dropped
// or repeated.
module look_at_view_matrix_unit
  import lvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] in_eye_x,
  input  logic signed [DW-1:0] in_eye_y,
  input  logic signed [DW-1:0] in_eye_z,
  input  logic signed [DW-1:0] in_target_x,
  input  logic signed [DW-1:0] in_target_y,
  input  logic signed [DW-1:0] in_target_z,
  input  logic signed [DW-1:0] in_upward_x,
  input  logic signed [DW-1:0] in_upward_y,
  input  logic signed [DW-1:0] in_upward_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_column_index,
  output logic signed [DW-1:0] out_row0_value,
  output logic signed [DW-1:0] out_row1_value,
  output logic signed [DW-1:0] out_row2_value,
  output logic signed [DW-1:0] out_row3_value,
  output logic                 out_degenerate,
  output logic                 out_last_column
);

  // Global advance: the pipeline moves whenever the output register is empty or
  // is sending the final column of its matrix in this cycle.
  logic en;

  // Stage 0: request register.
  logic                 v0_r;
  logic signed [DW-1:0] eye0_r [3];
  logic signed [DW-1:0] tgt0_r [3];
  logic signed [DW-1:0] up0_r  [3];
  // Stage 1: direction to target.
  logic                 v1_r;
  logic signed [CW-1:0] d1_r   [3];
  logic signed [DW-1:0] eye1_r [3];
  logic signed [DW-1:0] up1_r  [3];
  // Side data alongside the first normaliser.
  logic                 dl1_v_r   [NORM_LAT];
  logic signed [DW-1:0] dl1_eye_r [NORM_LAT][3];
  logic signed [DW-1:0] dl1_up_r  [NORM_LAT][3];
  logic signed [UW-1:0] f_unit [3];
  logic                 f_zero;
  // Stages 2 and 3: side vector before normalising.
  logic                  v2_r;
  logic signed [XPW-1:0] xp2_r  [6];
  logic signed [UW-1:0]  f2_r   [3];
  logic signed [DW-1:0]  eye2_r [3];
  logic                  deg2_r;
  logic                  v3_r;
  logic signed [CW-1:0]  sc3_r  [3];
  logic signed [UW-1:0]  f3_r   [3];
  logic signed [DW-1:0]  eye3_r [3];
  logic                  deg3_r;
  // Side data alongside the second normaliser.
  logic                 dl2_v_r   [NORM_LAT];
  logic signed [DW-1:0] dl2_eye_r [NORM_LAT][3];
  logic signed [UW-1:0] dl2_f_r   [NORM_LAT][3];
  logic                 dl2_deg_r [NORM_LAT];
  logic signed [UW-1:0] s_unit [3];
  logic                 s_zero;
  // Stages 4 to 8: true up vector and translation.
  logic                  v4_r;
  logic signed [UPW-1:0] ps4_r  [6];
  logic signed [XPW-1:0] se4_r  [3];
  logic signed [XPW-1:0] fe4_r  [3];
  logic signed [UW-1:0]  s4_r   [3];
  logic signed [UW-1:0]  f4_r   [3];
  logic signed [DW-1:0]  eye4_r [3];
  logic                  deg4_r;
  logic                  v5_r;
  logic signed [UCW-1:0] uc5_r  [3];
  logic signed [DTW-1:0] sd5_r;
  logic signed [DTW-1:0] fd5_r;
  logic signed [UW-1:0]  s5_r   [3];
  logic signed [UW-1:0]  f5_r   [3];
  logic signed [DW-1:0]  eye5_r [3];
  logic                  deg5_r;
  logic                  v6_r;
  logic signed [DW-1:0]  u6_r   [3];
  logic signed [DW-1:0]  t0_6_r;
  logic signed [DW-1:0]  t2_6_r;
  logic signed [UW-1:0]  s6_r   [3];
  logic signed [UW-1:0]  f6_r   [3];
  logic signed [DW-1:0]  eye6_r [3];
  logic                  deg6_r;
  logic                  v7_r;
  logic signed [EPW-1:0] ue7_r  [3];
  logic signed [DW-1:0]  u7_r   [3];
  logic signed [DW-1:0]  t0_7_r;
  logic signed [DW-1:0]  t2_7_r;
  logic signed [UW-1:0]  s7_r   [3];
  logic signed [UW-1:0]  f7_r   [3];
  logic                  deg7_r;
  logic                  v8_r;
  logic signed [RW-1:0]  ud8_r;
  logic signed [DW-1:0]  u8_r   [3];
  logic signed [DW-1:0]  t0_8_r;
  logic signed [DW-1:0]  t2_8_r;
  logic signed [UW-1:0]  s8_r   [3];
  logic signed [UW-1:0]  f8_r   [3];
  logic                  deg8_r;
  // Output register: one finished matrix, sent a column at a time.
  logic                  mat_v_r;
  col_t                  col_r;
  logic signed [UW-1:0]  mat_s_r [3];
  logic signed [DW-1:0]  mat_u_r [3];
  logic signed [UW-1:0]  mat_f_r [3];
  logic signed [DW-1:0]  mat_t0_r;
  logic signed [DW-1:0]  mat_t1_r;
  logic signed [DW-1:0]  mat_t2_r;
  logic                  mat_deg_r;

  logic signed [DW-1:0] eye_in [3];
  logic signed [DW-1:0] tgt_in [3];
  logic signed [DW-1:0] up_in  [3];

  assign eye_in = '{in_eye_x, in_eye_y, in_eye_z};
  assign tgt_in = '{in_target_x, in_target_y, in_target_z};
  assign up_in  = '{in_upward_x, in_upward_y, in_upward_z};

  assign en       = !mat_v_r || (out_ready && (col_r == LAST_COL));
  assign in_ready = en;

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      v8_r    <= 1'b0;
      mat_v_r <= 1'b0;
      dl1_v_r <= '{default: 1'b0};
      dl2_v_r <= '{default: 1'b0};
    end else if (en) begin
      v0_r       <= in_valid;
      v1_r       <= v0_r;
      dl1_v_r[0] <= v1_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl1_v_r[k] <= dl1_v_r[k-1];
      end
      v2_r       <= dl1_v_r[NORM_LAT-1];
      v3_r       <= v2_r;
      dl2_v_r[0] <= v3_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl2_v_r[k] <= dl2_v_r[k-1];
      end
      v4_r    <= dl2_v_r[NORM_LAT-1];
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      v8_r    <= v7_r;
      mat_v_r <= v8_r;
    end
  end

  // Column counter of the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (en) begin
      col_r <= '0;
    end else if (out_ready) begin
      col_r <= col_r + 2'd1;
    end
  end

  // Front end: request capture and the direction to the target.
  always_ff @(posedge clk) begin
    if (en) begin
      eye0_r <= eye_in;
      tgt0_r <= tgt_in;
      up0_r  <= up_in;
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= CW'(tgt0_r[i]) - CW'(eye0_r[i]);
      end
      eye1_r <= eye0_r;
      up1_r  <= up0_r;
      dl1_eye_r[0] <= eye1_r;
      dl1_up_r[0]  <= up1_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl1_eye_r[k] <= dl1_eye_r[k-1];
        dl1_up_r[k]  <= dl1_up_r[k-1];
      end
    end
  end

  lvm_norm u_norm_f (
    .clk    (clk),
    .en     (en),
    .vec_i  (d1_r),
    .unit_o (f_unit),
    .zero_o (f_zero)
  );

  // Side vector: cross(f, up) kept at full product precision.
  always_ff @(posedge clk) begin
    if (en) begin
      xp2_r[0] <= XPW'(f_unit[1]) * XPW'(dl1_up_r[NORM_LAT-1][2]);
      xp2_r[1] <= XPW'(f_unit[2]) * XPW'(dl1_up_r[NORM_LAT-1][1]);
      xp2_r[2] <= XPW'(f_unit[2]) * XPW'(dl1_up_r[NORM_LAT-1][0]);
      xp2_r[3] <= XPW'(f_unit[0]) * XPW'(dl1_up_r[NORM_LAT-1][2]);
      xp2_r[4] <= XPW'(f_unit[0]) * XPW'(dl1_up_r[NORM_LAT-1][1]);
      xp2_r[5] <= XPW'(f_unit[1]) * XPW'(dl1_up_r[NORM_LAT-1][0]);
      f2_r     <= f_unit;
      eye2_r   <= dl1_eye_r[NORM_LAT-1];
      deg2_r   <= f_zero;
      sc3_r[0] <= CW'(xp2_r[0]) - CW'(xp2_r[1]);
      sc3_r[1] <= CW'(xp2_r[2]) - CW'(xp2_r[3]);
      sc3_r[2] <= CW'(xp2_r[4]) - CW'(xp2_r[5]);
      f3_r     <= f2_r;
      eye3_r   <= eye2_r;
      deg3_r   <= deg2_r;
      dl2_eye_r[0] <= eye3_r;
      dl2_f_r[0]   <= f3_r;
      dl2_deg_r[0] <= deg3_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl2_eye_r[k] <= dl2_eye_r[k-1];
        dl2_f_r[k]   <= dl2_f_r[k-1];
        dl2_deg_r[k] <= dl2_deg_r[k-1];
      end
    end
  end

  lvm_norm u_norm_s (
    .clk    (clk),
    .en     (en),
    .vec_i  (sc3_r),
    .unit_o (s_unit),
    .zero_o (s_zero)
  );

  // Back end: u = cross(s, f), the three dot products with the eye point, rounding
  // and saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      ps4_r[0] <= UPW'(s_unit[1]) * UPW'(dl2_f_r[NORM_LAT-1][2]);
      ps4_r[1] <= UPW'(s_unit[2]) * UPW'(dl2_f_r[NORM_LAT-1][1]);
      ps4_r[2] <= UPW'(s_unit[2]) * UPW'(dl2_f_r[NORM_LAT-1][0]);
      ps4_r[3] <= UPW'(s_unit[0]) * UPW'(dl2_f_r[NORM_LAT-1][2]);
      ps4_r[4] <= UPW'(s_unit[0]) * UPW'(dl2_f_r[NORM_LAT-1][1]);
      ps4_r[5] <= UPW'(s_unit[1]) * UPW'(dl2_f_r[NORM_LAT-1][0]);
      for (int i = 0; i < 3; i++) begin
        se4_r[i] <= XPW'(s_unit[i]) * XPW'(dl2_eye_r[NORM_LAT-1][i]);
        fe4_r[i] <= XPW'(dl2_f_r[NORM_LAT-1][i]) * XPW'(dl2_eye_r[NORM_LAT-1][i]);
      end
      s4_r   <= s_unit;
      f4_r   <= dl2_f_r[NORM_LAT-1];
      eye4_r <= dl2_eye_r[NORM_LAT-1];
      deg4_r <= dl2_deg_r[NORM_LAT-1] || s_zero;

      uc5_r[0] <= UCW'(ps4_r[0]) - UCW'(ps4_r[1]);
      uc5_r[1] <= UCW'(ps4_r[2]) - UCW'(ps4_r[3]);
      uc5_r[2] <= UCW'(ps4_r[4]) - UCW'(ps4_r[5]);
      sd5_r    <= DTW'(se4_r[0]) + DTW'(se4_r[1]) + DTW'(se4_r[2]);
      fd5_r    <= DTW'(fe4_r[0]) + DTW'(fe4_r[1]) + DTW'(fe4_r[2]);
      s5_r     <= s4_r;
      f5_r     <= f4_r;
      eye5_r   <= eye4_r;
      deg5_r   <= deg4_r;

      for (int i = 0; i < 3; i++) begin
        u6_r[i] <= sat_dw(round_frac(RW'(uc5_r[i])));
      end
      t0_6_r <= sat_dw(-round_frac(RW'(sd5_r)));
      t2_6_r <= sat_dw(round_frac(RW'(fd5_r)));
      s6_r   <= s5_r;
      f6_r   <= f5_r;
      eye6_r <= eye5_r;
      deg6_r <= deg5_r;

      for (int i = 0; i < 3; i++) begin
        ue7_r[i] <= EPW'(u6_r[i]) * EPW'(eye6_r[i]);
      end
      u7_r   <= u6_r;
      t0_7_r <= t0_6_r;
      t2_7_r <= t2_6_r;
      s7_r   <= s6_r;
      f7_r   <= f6_r;
      deg7_r <= deg6_r;

      ud8_r  <= RW'(ue7_r[0]) + RW'(ue7_r[1]) + RW'(ue7_r[2]);
      u8_r   <= u7_r;
      t0_8_r <= t0_7_r;
      t2_8_r <= t2_7_r;
      s8_r   <= s7_r;
      f8_r   <= f7_r;
      deg8_r <= deg7_r;

      mat_s_r   <= s8_r;
      mat_u_r   <= u8_r;
      mat_f_r   <= f8_r;
      mat_t0_r  <= t0_8_r;
      mat_t1_r  <= sat_dw(-round_frac(ud8_r));
      mat_t2_r  <= t2_8_r;
      mat_deg_r <= deg8_r;
    end
  end

  // Column selection from the output register.
  always_comb begin
    case (col_r)
      2'd0: begin
        out_row0_value = DW'(mat_s_r[0]);
        out_row1_value = mat_u_r[0];
        out_row2_value = -DW'(mat_f_r[0]);
        out_row3_value = '0;
      end
      2'd1: begin
        out_row0_value = DW'(mat_s_r[1]);
        out_row1_value = mat_u_r[1];
        out_row2_value = -DW'(mat_f_r[1]);
        out_row3_value = '0;
      end
      2'd2: begin
        out_row0_value = DW'(mat_s_r[2]);
        out_row1_value = mat_u_r[2];
        out_row2_value = -DW'(mat_f_r[2]);
        out_row3_value = '0;
      end
      default: begin
        out_row0_value = mat_t0_r;
        out_row1_value = mat_t1_r;
        out_row2_value = mat_t2_r;
        out_row3_value = DW'(1) << FRAC_BITS;
      end
    endcase
  end

  assign out_valid        = mat_v_r;
  assign out_column_index = col_r;
  assign out_degenerate   = mat_deg_r;
  assign out_last_column  = (col_r == LAST_COL);

endmodule

[rtl/lvm_norm.sv]
module lvm_norm
  import lvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] vec_i  [3],
  output logic signed [UW-1:0] unit_o [3],
  output logic                 zero_o
);

  // Magnitudes and signs.
  logic [CW-1:0]  mag1_r [3];
  logic [2:0]     neg1_r;
  // Leading one of the largest magnitude.
  logic [CW-1:0]  mag2_r [3];
  logic [2:0]     neg2_r;
  logic [PW-1:0]  pos2_r;
  logic           zero2_r;
  // Scaled magnitudes.
  logic [NMW-1:0] m3_r [3];
  logic [2:0]     neg3_r;
  logic           zero3_r;
  // Squares and their sum.
  logic [2*NMW-1:0] sq4_r [3];
  logic [NMW-1:0] m4_r [3];
  logic [2:0]     neg4_r;
  logic           zero4_r;
  logic [SQW-1:0] sum5_r;
  logic [NMW-1:0] m5_r [3];
  logic [2:0]     neg5_r;
  logic           zero5_r;
  // Square root, one result bit per stage.
  logic [SQW-1:0] sqx_r   [SQ_STEPS];
  logic [SQW-1:0] sqres_r [SQ_STEPS];
  logic [NMW-1:0] sqm_r   [SQ_STEPS][3];
  logic [2:0]     sqneg_r [SQ_STEPS];
  logic           sqzero_r[SQ_STEPS];
  // Division set-up and one quotient bit per stage.
  logic [DVW-1:0] prnum_r [3];
  logic [LW-1:0]  prlen_r;
  logic [2:0]     prneg_r;
  logic           przero_r;
  logic [DVW-1:0] dvrem_r [QW][3];
  logic [QW-1:0]  dvq_r   [QW][3];
  logic [LW-1:0]  dvlen_r [QW];
  logic [2:0]     dvneg_r [QW];
  logic           dvzero_r[QW];
  logic signed [UW-1:0] unit_r [3];
  logic           zero_r;

  logic [CW-1:0]  or1;
  assign or1 = mag1_r[0] | mag1_r[1] | mag1_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= vec_i[i][CW-1] ? CW'(-vec_i[i]) : CW'(vec_i[i]);
        neg1_r[i] <= vec_i[i][CW-1];
      end
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      pos2_r  <= lead_one(or1);
      zero2_r <= !(|or1);
      for (int i = 0; i < 3; i++) begin
        if (pos2_r > PW'(MT)) begin
          m3_r[i] <= NMW'(mag2_r[i] >> (pos2_r - PW'(MT)));
        end else begin
          m3_r[i] <= NMW'(mag2_r[i] << (PW'(MT) - pos2_r));
        end
      end
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= (2*NMW)'(m3_r[i]) * (2*NMW)'(m3_r[i]);
      end
      m4_r    <= m3_r;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      sum5_r  <= SQW'(sq4_r[0]) + SQW'(sq4_r[1]) + SQW'(sq4_r[2]);
      m5_r    <= m4_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQW-1:0] px;
    logic [SQW-1:0] pres;
    logic [NMW-1:0] pm [3];
    logic [2:0]     pneg;
    logic           pzero;
    logic [SQW:0]   trial;
    if (k == 0) begin : g_first
      assign px    = sum5_r;
      assign pres  = '0;
      assign pm    = m5_r;
      assign pneg  = neg5_r;
      assign pzero = zero5_r;
    end else begin : g_next
      assign px    = sqx_r[k-1];
      assign pres  = sqres_r[k-1];
      assign pm    = sqm_r[k-1];
      assign pneg  = sqneg_r[k-1];
      assign pzero = sqzero_r[k-1];
    end
    assign trial = {1'b0, pres} + {1'b0, BITV};
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, px} >= trial) begin
          sqx_r[k]   <= px - SQW'(trial);
          sqres_r[k] <= (pres >> 1) + BITV;
        end else begin
          sqx_r[k]   <= px;
          sqres_r[k] <= pres >> 1;
        end
        sqm_r[k]    <= pm;
        sqneg_r[k]  <= pneg;
        sqzero_r[k] <= pzero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prlen_r <= LW'(sqres_r[SQ_STEPS-1]);
      for (int i = 0; i < 3; i++) begin
        prnum_r[i] <= (DVW'(sqm_r[SQ_STEPS-1][i]) << FRAC_BITS)
                    + DVW'(sqres_r[SQ_STEPS-1][LW-1:1]);
      end
      prneg_r  <= sqneg_r[SQ_STEPS-1];
      przero_r <= sqzero_r[SQ_STEPS-1];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DVW-1:0] prem [3];
    logic [QW-1:0]  pq   [3];
    logic [LW-1:0]  plen;
    logic [2:0]     pneg;
    logic           pzero;
    logic [DVW-1:0] dvs;
    if (j == 0) begin : g_first
      assign prem  = prnum_r;
      assign pq    = '{default: '0};
      assign plen  = prlen_r;
      assign pneg  = prneg_r;
      assign pzero = przero_r;
    end else begin : g_next
      assign prem  = dvrem_r[j-1];
      assign pq    = dvq_r[j-1];
      assign plen  = dvlen_r[j-1];
      assign pneg  = dvneg_r[j-1];
      assign pzero = dvzero_r[j-1];
    end
    assign dvs = DVW'(plen) << (QW - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (prem[i] >= dvs) begin
            dvrem_r[j][i] <= prem[i] - dvs;
            dvq_r[j][i]   <= {pq[i][QW-2:0], 1'b1};
          end else begin
            dvrem_r[j][i] <= prem[i];
            dvq_r[j][i]   <= {pq[i][QW-2:0], 1'b0};
          end
        end
        dvlen_r[j]  <= plen;
        dvneg_r[j]  <= pneg;
        dvzero_r[j] <= pzero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dvzero_r[QW-1]) begin
          unit_r[i] <= '0;
        end else if (dvneg_r[QW-1][i]) begin
          unit_r[i] <= -$signed(UW'(dvq_r[QW-1][i]));
        end else begin
          unit_r[i] <= $signed(UW'(dvq_r[QW-1][i]));
        end
      end
      zero_r <= dvzero_r[QW-1];
    end
  end

  assign unit_o = unit_r;
  assign zero_o = zero_r;

endmodule

[test/look_at_view_matrix_unit_tb.sv]
module look_at_view_matrix_unit_tb;
  import lvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One request as the block sees it: eye point, target point and up vector.
  typedef struct packed {
    logic signed [31:0] ex, ey, ez;
    logic signed [31:0] tx, ty, tz;
    logic signed [31:0] ux, uy, uz;
  } view_req_t;

  // One column of the view matrix as it leaves the block.
  typedef struct packed {
    logic [1:0]         idx;
    logic signed [31:0] r0, r1, r2, r3;
    logic               degen;
    logic               last;
  } view_col_t;

  localparam int        NUM_RANDOM  = 120;
  localparam longint    CYCLE_LIMIT = 400000;
  localparam int        DRAIN_WAIT  = 200;
  localparam longint    ONE_Q       = 64'sd1 <<< FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [31:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic signed [31:0] in_upward_x = '0, in_upward_y = '0, in_upward_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_column_index;
  logic signed [31:0] out_row0_value, out_row1_value, out_row2_value, out_row3_value;
  logic               out_degenerate;
  logic               out_last_column;

  view_req_t pending_reqs[$];
  view_col_t expected_cols[$];
  int        error_count = 0;
  longint    cycle_count = 0;
  bit        stimulus_loaded = 1'b0;

  // Idling control. Each side idles in about one cycle in ten, apart from a
  // quiet window in which neither does. The receiver also holds off once for
  // a long stretch so that the pipeline fills and in_ready drops.
  bit     quiet_window = 1'b0;
  bit     hold_request = 1'b0;
  int     hold_left = 0;

  look_at_view_matrix_unit i_dut (.*);

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor arithmetic. Everything is carried in 64-bit signed values, which
  // is wide enough for the products of a unit component and a Q16.16 value.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Drops the fraction bits of a full-precision product, half away from zero.
  function automatic longint round_q(longint v);
    longint unsigned m;
    m = (abs64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Turns a vector into a unit vector. The magnitudes are brought to a common
  // scale with the largest in [2^29, 2^30) first; a zero vector stays zero
  // and is reported back so the degenerate flag can be raised.
  function automatic bit unit_vector(input longint v[3], output longint u[3]);
    longint unsigned m[3];
    longint unsigned top, sum, len, q;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    while (top >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      top <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint dot_prod(input longint a[3], input longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Works out the four columns that one request must produce and queues them.
  task automatic predict_view_matrix(input view_req_t r);
    longint    eye[3], tgt[3], up[3], dir[3], fwd[3], sc[3], side[3], uc[3], upv[3];
    longint    cols[4][4];
    bit        degen;
    view_col_t c;
    eye = '{longint'(r.ex), longint'(r.ey), longint'(r.ez)};
    tgt = '{longint'(r.tx), longint'(r.ty), longint'(r.tz)};
    up  = '{longint'(r.ux), longint'(r.uy), longint'(r.uz)};
    for (int i = 0; i < 3; i++) dir[i] = tgt[i] - eye[i];
    degen = unit_vector(dir, fwd);
    cross_prod(fwd, up, sc);
    if (unit_vector(sc, side)) degen = 1'b1;
    cross_prod(side, fwd, uc);
    for (int i = 0; i < 3; i++) upv[i] = clamp32(round_q(uc[i]));
    for (int i = 0; i < 3; i++) begin
      cols[i][0] = clamp32(side[i]);
      cols[i][1] = upv[i];
      cols[i][2] = clamp32(-fwd[i]);
      cols[i][3] = 0;
    end
    cols[3][0] = clamp32(round_q(-dot_prod(side, eye)));
    cols[3][1] = clamp32(round_q(-dot_prod(upv, eye)));
    cols[3][2] = clamp32(round_q(dot_prod(fwd, eye)));
    cols[3][3] = ONE_Q;
    for (int k = 0; k < 4; k++) begin
      c.idx   = 2'(k);
      c.r0    = cols[k][0][31:0];
      c.r1    = cols[k][1][31:0];
      c.r2    = cols[k][2][31:0];
      c.r3    = cols[k][3][31:0];
      c.degen = degen;
      c.last  = (c.idx == LAST_COL);
      expected_cols.push_back(c);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("[%0t] column mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_word();
    // Mostly modest coordinates, with full-range words and extremes mixed in so
    // that the translation column is driven into saturation now and then.
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $urandom();
      default: return $signed(32'($urandom_range(0, 32'h00ff_ffff))) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic view_req_t rand_request();
    view_req_t r;
    r.ex = rand_word(); r.ey = rand_word(); r.ez = rand_word();
    r.tx = rand_word(); r.ty = rand_word(); r.tz = rand_word();
    r.ux = rand_word(); r.uy = rand_word(); r.uz = rand_word();
    case ($urandom_range(0, 19))
      0: begin
        // The target sits on the eye, so the forward vector is zero.
        r.tx = r.ex; r.ty = r.ey; r.tz = r.ez;
      end
      1: begin
        // The up vector is a multiple of the viewing direction.
        r.ux = (r.tx - r.ex) >>> 2; r.uy = (r.ty - r.ey) >>> 2; r.uz = (r.tz - r.ez) >>> 2;
      end
      2: begin
        r.ux = '0; r.uy = '0; r.uz = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic view_req_t make_req(longint ex, longint ey, longint ez,
                                         longint tx, longint ty, longint tz,
                                         longint ux, longint uy, longint uz);
    view_req_t r;
    r.ex = ex[31:0]; r.ey = ey[31:0]; r.ez = ez[31:0];
    r.tx = tx[31:0]; r.ty = ty[31:0]; r.tz = tz[31:0];
    r.ux = ux[31:0]; r.uy = uy[31:0]; r.uz = uz[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: a directed set first, then random requests.
  // ---------------------------------------------------------------------------
  initial begin
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // Plain camera at five units on +z looking at the origin, y up.
    pending_reqs.push_back(make_req(0, 0, 5 * ONE_Q, 0, 0, 0, 0, ONE_Q, 0));
    // Target equals eye: forward vector has no length.
    pending_reqs.push_back(make_req(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, ONE_Q, 2 * ONE_Q, 3 * ONE_Q,
                                    0, ONE_Q, 0));
    // Up vector parallel to the viewing direction.
    pending_reqs.push_back(make_req(0, 0, 0, 0, 7 * ONE_Q, 0, 0, ONE_Q, 0));
    // Up vector of zero length.
    pending_reqs.push_back(make_req(0, 0, 0, ONE_Q, 0, 0, 0, 0, 0));
    // Extreme eye and target, so the difference spans 33 bits and the
    // translation saturates.
    pending_reqs.push_back(make_req(mx, mx, mx, mn, mn, mn, mn, mx, 0));
    pending_reqs.push_back(make_req(mn, mn, mn, mx, mx, mx, mx, mn, mx));
    pending_reqs.push_back(make_req(mn, 0, 0, mx, 0, 0, 0, mn, 0));
    pending_reqs.push_back(make_req(mx, mn, mx, mx, mx, mn, 1, -1, 1));
    // Smallest possible offsets, which the normaliser must scale up.
    pending_reqs.push_back(make_req(0, 0, 0, 1, 0, 0, 0, 0, 1));
    pending_reqs.push_back(make_req(-1, -1, -1, 0, 0, 0, -1, 1, 0));
    // Every bit set and every bit clear.
    pending_reqs.push_back(make_req(-1, -1, -1, -1, 0, -1, -1, -1, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, -ONE_Q, mx, mx, mx));
    for (int i = 0; i < NUM_RANDOM; i++) pending_reqs.push_back(rand_request());
    stimulus_loaded = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Reset, idle pattern and the long receiver hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    // A stretch with no idling on either side once the hold-off is over.
    quiet_window <= (cycle_count > 600 && cycle_count < 900);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Early in the run, once columns are flowing, the receiver stops taking
  // them for a long time while the sender keeps offering requests.
  always @(posedge clk) begin
    if (cycle_count == 200) begin
      hold_request <= 1'b1;
      hold_left    <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_request <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. Valid goes high without waiting for ready and holds its request
  // until the handshake; a new request may follow in the very next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    view_req_t r;
    bit        busy;
    if (rst_n) begin
      busy = in_valid && !in_ready;
      if (!busy) begin
        if (in_valid && in_ready) predict_view_matrix(pending_reqs.pop_front());
        if (pending_reqs.size() > 0 && (quiet_window || $urandom_range(0, 99) >= 10)) begin
          r = pending_reqs[0];
          in_valid    <= 1'b1;
          in_eye_x    <= r.ex; in_eye_y    <= r.ey; in_eye_z    <= r.ez;
          in_target_x <= r.tx; in_target_y <= r.ty; in_target_z <= r.tz;
          in_upward_x <= r.ux; in_upward_y <= r.uy; in_upward_z <= r.uz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and result-side ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    view_col_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_cols.size() == 0) begin
          report_mismatch("unexpected column", out_column_index, -1);
        end else begin
          w = expected_cols.pop_front();
          if (out_column_index !== w.idx) report_mismatch("column_index", out_column_index, w.idx);
          if (out_row0_value !== w.r0) report_mismatch("row0_value", out_row0_value, w.r0);
          if (out_row1_value !== w.r1) report_mismatch("row1_value", out_row1_value, w.r1);
          if (out_row2_value !== w.r2) report_mismatch("row2_value", out_row2_value, w.r2);
          if (out_row3_value !== w.r3) report_mismatch("row3_value", out_row3_value, w.r3);
          if (out_degenerate !== w.degen) report_mismatch("degenerate", out_degenerate, w.degen);
          if (out_last_column !== w.last) report_mismatch("last_column", out_last_column, w.last);
        end
      end
      out_ready <= !hold_request && (quiet_window || $urandom_range(0, 99) >= 10);
    end
  end

  // ---------------------------------------------------------------------------
  // End of run: all requests taken, every column back, then a quiet drain.
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_n && stimulus_loaded);
    while (pending_reqs.size() > 0 || in_valid || expected_cols.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_cols.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
